// ===== hdl/ffba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, types and helpers of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_W     = 16;
	localparam int IDX_W      = 4;
	localparam int CFG_W      = 5;
	localparam int SUM_W      = 20;
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	// One command as classified by the front end.
	typedef struct packed {
		logic              is_alloc;
		logic              wr_en;
		logic [IDX_W-1:0]  index;
		logic [SIZE_W-1:0] size;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_SCAN = 3'b100
	} back_state_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [SIZE_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ffba_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ffba_req_if;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [ffba_pkg::IDX_W-1:0]  block_index;
	logic [ffba_pkg::SIZE_W-1:0] size_value;

	modport source (output valid, operation, block_index, size_value, input ready);
	modport sink   (input valid, operation, block_index, size_value, output ready);
endinterface

interface ffba_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       granted;
	logic [ffba_pkg::IDX_W-1:0]  chosen_index;
	logic [ffba_pkg::SIZE_W-1:0] leftover;
	logic [ffba_pkg::SUM_W-1:0]  total_internal;
	logic [ffba_pkg::SUM_W-1:0]  total_external;

	modport source (output valid, granted, chosen_index, leftover, total_internal,
		total_external, input ready);
	modport sink   (input valid, granted, chosen_index, leftover, total_internal,
		total_external, output ready);
endinterface

interface ffba_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ffba_pkg::CFG_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ffba_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_front
// Accepts request beats, classifies them into commands and queues them in a
// two-entry FIFO ahead of the table sequencer.
// ----------------------------------------------------------------------------
module ffba_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ffba_req_if.sink            items,
	output ffba_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_ready
);

	ffba_pkg::cmd_t queue_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	ffba_pkg::cmd_t incoming;
	logic           push;
	logic           pop;

	// A load aimed outside the table is kept as a beat but writes nothing.
	always_comb begin
		incoming.is_alloc = (items.operation == ffba_pkg::OP_ALLOC);
		incoming.wr_en    = (items.operation == ffba_pkg::OP_LOAD) &&
			(ffba_pkg::CNT_W'(items.block_index) < ffba_pkg::CNT_W'(ffba_pkg::NUM_BLOCKS));
		incoming.index    = items.block_index;
		incoming.size     = items.size_value;
	end

	assign items.ready = (fill_q != 2'd2);
	assign cmd_valid   = (fill_q != 2'd0);
	assign cmd         = queue_q[rd_ptr_q];
	assign push        = items.valid && items.ready;
	assign pop         = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ffba_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_back
// Partition table and scan sequencer. One pass over the active entries finds
// the first fit and accumulates both fragmentation totals; the result goes to
// an output register.
// ----------------------------------------------------------------------------
module ffba_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ffba_pkg::cmd_t              cmd,
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire logic [ffba_pkg::CNT_W-1:0]  active_cnt,
	ffba_rsp_if.source                       results
);

	ffba_pkg::back_state_t          state_q;
	ffba_pkg::cmd_t                 cmd_q;
	logic [ffba_pkg::SIZE_W-1:0]    size_q [ffba_pkg::NUM_BLOCKS];
	logic [ffba_pkg::SIZE_W-1:0]    rest_q [ffba_pkg::NUM_BLOCKS];
	logic [ffba_pkg::NUM_BLOCKS-1:0] free_q;
	logic [ffba_pkg::CNT_W-1:0]     scan_q;
	logic                           hit_q;
	logic [ffba_pkg::IDX_W-1:0]     pick_q;
	logic [ffba_pkg::SIZE_W-1:0]    left_q;
	logic [ffba_pkg::SUM_W-1:0]     in_sum_q;
	logic [ffba_pkg::SUM_W-1:0]     ex_sum_q;

	logic                           out_valid_q;
	logic                           out_granted_q;
	logic [ffba_pkg::IDX_W-1:0]     out_index_q;
	logic [ffba_pkg::SIZE_W-1:0]    out_left_q;
	logic [ffba_pkg::SUM_W-1:0]     out_in_q;
	logic [ffba_pkg::SUM_W-1:0]     out_ex_q;

	logic [ffba_pkg::IDX_W-1:0]     cur;
	logic [ffba_pkg::SIZE_W-1:0]    cur_size;
	logic [ffba_pkg::SIZE_W-1:0]    diff;
	logic                           fit;
	logic                           out_free;
	logic                           finish;

	assign cur       = scan_q[ffba_pkg::IDX_W-1:0];
	assign cur_size  = size_q[cur];
	assign diff      = cur_size - cmd_q.size;
	assign fit       = cmd_q.is_alloc && !hit_q && free_q[cur] && (cur_size >= cmd_q.size);
	assign out_free  = !out_valid_q || results.ready;
	assign finish    = (state_q == ffba_pkg::ST_SCAN) && (scan_q == active_cnt) && out_free;
	assign cmd_ready = (state_q == ffba_pkg::ST_IDLE);

	assign results.valid          = out_valid_q;
	assign results.granted        = out_granted_q;
	assign results.chosen_index   = out_index_q;
	assign results.leftover       = out_left_q;
	assign results.total_internal = out_in_q;
	assign results.total_external = out_ex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffba_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			free_q      <= '1;
			for (int i = 0; i < ffba_pkg::NUM_BLOCKS; i++) begin
				size_q[i] <= '0;
				rest_q[i] <= '0;
			end
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ffba_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= cmd.is_alloc ? ffba_pkg::ST_SCAN : ffba_pkg::ST_LOAD;
					end
				end
				ffba_pkg::ST_LOAD: begin
					if (cmd_q.wr_en) begin
						size_q[cmd_q.index] <= cmd_q.size;
						rest_q[cmd_q.index] <= '0;
						free_q[cmd_q.index] <= 1'b1;
					end
					state_q <= ffba_pkg::ST_SCAN;
				end
				ffba_pkg::ST_SCAN: begin
					if (scan_q == active_cnt) begin
						// Hold the finished result until the output register drains.
						if (out_free) begin
							state_q <= ffba_pkg::ST_IDLE;
						end
					end else if (fit) begin
						free_q[cur] <= 1'b0;
						rest_q[cur] <= diff;
					end
				end
				default: begin
					state_q <= ffba_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ffba_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q    <= cmd;
					scan_q   <= '0;
					hit_q    <= 1'b0;
					pick_q   <= '0;
					left_q   <= '0;
					in_sum_q <= '0;
					ex_sum_q <= '0;
				end
			end
			ffba_pkg::ST_SCAN: begin
				if (scan_q == active_cnt) begin
					if (out_free) begin
						out_granted_q <= hit_q;
						out_index_q   <= pick_q;
						out_left_q    <= left_q;
						out_in_q      <= in_sum_q;
						out_ex_q      <= ex_sum_q;
					end
				end else begin
					scan_q <= scan_q + ffba_pkg::CNT_W'(1);
					if (fit) begin
						hit_q    <= 1'b1;
						pick_q   <= cur;
						left_q   <= diff;
						in_sum_q <= ffba_pkg::sat_add(in_sum_q, diff);
					end else if (free_q[cur]) begin
						ex_sum_q <= ffba_pkg::sat_add(ex_sum_q, cur_size);
					end else begin
						in_sum_q <= ffba_pkg::sat_add(in_sum_q, rest_q[cur]);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/first_fit_block_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a fixed table of partitions with fragmentation
// totals.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one result beat. The sequencer walks the
// first min(block_count, 16) entries of the table one entry per cycle, and that
// single walk both finds the first fit and rebuilds the two totals; a load first
// writes its entry. A two-entry queue in front of the sequencer keeps taking
// beats while it has room, also while a result waits in the output register.
// block_count may be written only while the block is idle; values above 16 act as 16.
module first_fit_block_allocator (
	input  wire logic clk,
	input  wire logic arst_n,
	ffba_req_if.sink   items,
	ffba_rsp_if.source results,
	ffba_cfg_if.sink   cfg
);

	logic [ffba_pkg::CFG_W-1:0] count_q;
	logic [ffba_pkg::CNT_W-1:0] active_cnt;
	ffba_pkg::cmd_t             cmd;
	logic                       cmd_valid;
	logic                       cmd_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.data;
		end
	end

	assign active_cnt = (count_q > ffba_pkg::CFG_W'(ffba_pkg::NUM_BLOCKS)) ?
		ffba_pkg::CNT_W'(ffba_pkg::NUM_BLOCKS) : ffba_pkg::CNT_W'(count_q);

	ffba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	ffba_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.active_cnt (active_cnt),
		.results    (results)
	);

	// A result without a grant reports no index and no leftover.
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.granted |->
			results.chosen_index == '0 && results.leftover == '0)
		else $error("ungranted result carries index or leftover");

	// A granted index always lies inside the active part of the table.
	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.granted |->
			ffba_pkg::CNT_W'(results.chosen_index) < active_cnt)
		else $error("granted index outside active entries");

	// The sequencer is busy in the cycle after taking a command.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("sequencer took two commands back to back");

endmodule
`default_nettype wire

// ===== tb/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the request, result and configuration channels of the first-fit
// block allocator. It keeps its own copy of the partition table, predicts
// the result of every accepted request beat and compares each result beat,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ffba_checker (
	input  logic       clk,
	input  logic       arst_n,
	ffba_req_if        items,
	ffba_rsp_if        results,
	ffba_cfg_if        cfg,
	output int         fail_count,
	output int         pending
);

	typedef struct {
		logic                        granted;
		logic [ffba_pkg::IDX_W-1:0]  chosen_index;
		logic [ffba_pkg::SIZE_W-1:0] leftover;
		logic [ffba_pkg::SUM_W-1:0]  total_internal;
		logic [ffba_pkg::SUM_W-1:0]  total_external;
	} alloc_result_t;

	logic [ffba_pkg::SIZE_W-1:0] part_size [ffba_pkg::NUM_BLOCKS];
	logic [ffba_pkg::SIZE_W-1:0] part_leftover [ffba_pkg::NUM_BLOCKS];
	bit                          part_free [ffba_pkg::NUM_BLOCKS];
	logic [ffba_pkg::CFG_W-1:0]  active_setting;
	alloc_result_t               awaited_results[$];

	task automatic report(input string msg);
		$display("%0t ffba_checker: %s", $time, msg);
		fail_count++;
	endtask

	// Applies one request to the table and returns the result it must give.
	function automatic alloc_result_t predict_allocation(input logic op,
			input logic [ffba_pkg::IDX_W-1:0] idx,
			input logic [ffba_pkg::SIZE_W-1:0] request);
		alloc_result_t r;
		int            span;
		logic [ffba_pkg::SUM_W:0] in_sum;
		logic [ffba_pkg::SUM_W:0] ex_sum;
		r = '{granted: 1'b0, chosen_index: '0, leftover: '0,
			total_internal: '0, total_external: '0};
		span = (active_setting > ffba_pkg::NUM_BLOCKS) ? ffba_pkg::NUM_BLOCKS :
			int'(active_setting);
		if (op == ffba_pkg::OP_LOAD) begin
			if (idx < ffba_pkg::NUM_BLOCKS) begin
				part_size[idx]     = request;
				part_free[idx]     = 1'b1;
				part_leftover[idx] = '0;
			end
		end else begin
			for (int i = 0; i < span; i++) begin
				if (!r.granted && part_free[i] && part_size[i] >= request) begin
					part_free[i]     = 1'b0;
					part_leftover[i] = part_size[i] - request;
					r.granted        = 1'b1;
					r.chosen_index   = i[ffba_pkg::IDX_W-1:0];
					r.leftover       = part_leftover[i];
				end
			end
		end
		in_sum = '0;
		ex_sum = '0;
		for (int i = 0; i < span; i++) begin
			if (part_free[i])
				ex_sum += (ffba_pkg::SUM_W+1)'(part_size[i]);
			else
				in_sum += (ffba_pkg::SUM_W+1)'(part_leftover[i]);
			if (ex_sum > {1'b0, {ffba_pkg::SUM_W{1'b1}}})
				ex_sum = {1'b0, {ffba_pkg::SUM_W{1'b1}}};
			if (in_sum > {1'b0, {ffba_pkg::SUM_W{1'b1}}})
				in_sum = {1'b0, {ffba_pkg::SUM_W{1'b1}}};
		end
		r.total_internal = in_sum[ffba_pkg::SUM_W-1:0];
		r.total_external = ex_sum[ffba_pkg::SUM_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		alloc_result_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < ffba_pkg::NUM_BLOCKS; i++) begin
				part_size[i]     = '0;
				part_leftover[i] = '0;
				part_free[i]     = 1'b1;
			end
			active_setting = '0;
			awaited_results.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				active_setting = cfg.data;
			if (results.valid && results.ready) begin
				if (awaited_results.size() == 0) begin
					report("result beat with no request waiting for it");
				end else begin
					oldest = awaited_results.pop_front();
					if (results.granted !== oldest.granted)
						report($sformatf("granted: got %0d, expected %0d",
							results.granted, oldest.granted));
					if (results.chosen_index !== oldest.chosen_index)
						report($sformatf("chosen_index: got %0d, expected %0d",
							results.chosen_index, oldest.chosen_index));
					if (results.leftover !== oldest.leftover)
						report($sformatf("leftover: got %0d, expected %0d",
							results.leftover, oldest.leftover));
					if (results.total_internal !== oldest.total_internal)
						report($sformatf("total_internal: got %0d, expected %0d",
							results.total_internal, oldest.total_internal));
					if (results.total_external !== oldest.total_external)
						report($sformatf("total_external: got %0d, expected %0d",
							results.total_external, oldest.total_external));
				end
			end
			if (items.valid && items.ready)
				awaited_results.push_back(predict_allocation(items.operation,
					items.block_index, items.size_value));
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the first-fit block allocator. A directed run
// covers the size extremes, zero requests, failed fits, reloads of used
// partitions and block_count values of zero, partial and above the table.
// Random phases follow under several block_count settings and idling mixes.
// ----------------------------------------------------------------------------
module tb;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 75;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle_pct = 0;
	int   stall_pct = 0;

	int phase_setting [PHASES] = '{16, 16, 31, 0, 5, 16, 1, 17};
	int phase_idle    [PHASES] = '{0, 71, 0, 10, 71, 10, 0, 0};
	int phase_stall   [PHASES] = '{0, 0, 71, 10, 0, 10, 71, 71};

	ffba_req_if items_if ();
	ffba_rsp_if results_if ();
	ffba_cfg_if cfg_if ();

	first_fit_block_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	ffba_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items_if),
		.results    (results_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		results_if.ready <= ($urandom_range(0, 99) >= stall_pct);

	task automatic send_item(input ffba_pkg::op_t op,
			input logic [ffba_pkg::IDX_W-1:0] idx,
			input logic [ffba_pkg::SIZE_W-1:0] request);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid       <= 1'b1;
		items_if.operation   <= op;
		items_if.block_index <= idx;
		items_if.size_value  <= request;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_block_count(input logic [ffba_pkg::CFG_W-1:0] value);
		wait_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Mostly small sizes so that requests both fit and miss, with the
	// extremes and full-width values mixed in.
	function automatic logic [ffba_pkg::SIZE_W-1:0] pick_size();
		int pick;
		pick = $urandom_range(0, 9);
		unique case (pick)
			0: return '0;
			1: return {ffba_pkg::SIZE_W{1'b1}};
			2, 3: return ffba_pkg::SIZE_W'($urandom());
			default: return ffba_pkg::SIZE_W'($urandom_range(0, 2000));
		endcase
	endfunction

	initial begin
		arst_n               = 1'b0;
		items_if.valid      <= 1'b0;
		items_if.operation  <= ffba_pkg::OP_LOAD;
		items_if.block_index <= '0;
		items_if.size_value <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.data         <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With block_count at its reset value nothing is scanned.
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd0);
		send_item(ffba_pkg::OP_LOAD, 4'd3, 16'd100);

		write_block_count(5'd16);
		send_item(ffba_pkg::OP_LOAD, 4'd0, 16'd0);
		send_item(ffba_pkg::OP_LOAD, 4'd1, 16'hFFFF);
		send_item(ffba_pkg::OP_LOAD, 4'd15, 16'd1);
		send_item(ffba_pkg::OP_LOAD, 4'd7, 16'd500);
		send_item(ffba_pkg::OP_ALLOC, 4'd9, 16'd0);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'hFFFF);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'hFFFF);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd400);
		send_item(ffba_pkg::OP_ALLOC, 4'd15, 16'd1);
		// Reloading a used partition frees it and drops its leftover.
		send_item(ffba_pkg::OP_LOAD, 4'd1, 16'd40000);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd30000);

		// Partitions at or above block_count are neither scanned nor counted.
		write_block_count(5'd4);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd1);
		send_item(ffba_pkg::OP_LOAD, 4'd15, 16'hFFFF);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd2);

		// Values above the table size act as the full table.
		write_block_count(5'd31);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd1);
		send_item(ffba_pkg::OP_LOAD, 4'd9, 16'hFFFF);
		send_item(ffba_pkg::OP_LOAD, 4'd10, 16'hFFFF);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd1);
		send_item(ffba_pkg::OP_ALLOC, 4'd0, 16'd0);

		for (int p = 0; p < PHASES; p++) begin
			write_block_count(phase_setting[p][ffba_pkg::CFG_W-1:0]);
			send_idle_pct = phase_idle[p];
			stall_pct     = phase_stall[p];
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(($urandom_range(0, 99) < 45) ? ffba_pkg::OP_LOAD :
					ffba_pkg::OP_ALLOC,
					ffba_pkg::IDX_W'($urandom_range(0, ffba_pkg::NUM_BLOCKS - 1)),
					pick_size());
		end

		send_idle_pct = 0;
		stall_pct     = 0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
